// ===== design/rrt_tree_grow_2d_assert.svh =====
// Assertion macros for the tree grower.
// Included by the top level; relies on clk and rst being in scope.
`ifndef RRT_TREE_GROW_2D_ASSERT_SVH
`define RRT_TREE_GROW_2D_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define RRT_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A trigger that must be followed by a condition in the next cycle.
`define RRT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== design/rrt_pkg.sv =====
// Shared types, codes and constants of the tree grower.
// Used by the top level, rrt_search and rrt_steer; depends on nothing.
package rrt_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int COORD_W = 16;
  localparam int STEP_W = 15;
  localparam int DIFF_W = 18;
  localparam int D2_W = 34;
  localparam int SAMPLE_W = 7;
  localparam int OUT_IDX_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 15'd512;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [1:0] STATUS_ADDED = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
  } req_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]      new_index;
    logic [OUT_IDX_W-1:0]      parent_index;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic [1:0]                status;
  } res_t;

  typedef struct packed {
    logic [D2_W-1:0]           d2;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } best_t;

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [D2_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/rrt_tree_grow_2d.sv =====
// Top level of the 2D rapidly-exploring random tree grower.
// Depends on rrt_pkg, rrt_ram, rrt_search, rrt_steer and the assertion header.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  request  | start, busy               | req (kind, sample_x, sample_y)
//  result   | result_valid (one cycle)  | result
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// An add request keeps busy high through a scan that reads one node
// per cycle through the node RAM port, then 17 square root steps, one multiply
// and 32 divide steps. When the sample sits on its nearest node the divides are
// skipped. Restart and store-full requests never raise busy and strobe their
// result in the cycle after acceptance.
// Reset is synchronous; the tree then holds the root alone. The result strobe
// lasts one cycle and cannot be stalled; cfg_ready is always high.
`include "rrt_tree_grow_2d_assert.svh"

module rrt_tree_grow_2d #(
  parameter int MAX_NODES = rrt_pkg::MAX_NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rrt_pkg::req_t                     req,
  output logic                              result_valid,
  output rrt_pkg::res_t                     result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrt_pkg::COORD_W-1:0]       cfg_data
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_STEER} state_t;

  state_t state;

  logic signed [rrt_pkg::COORD_W-1:0] root_x, root_y;
  logic [rrt_pkg::STEP_W-1:0]         step_size;
  logic [CNT_W-1:0]                   count;
  logic signed [rrt_pkg::DIFF_W-1:0]  sx, sy;
  logic                               search_go, search_done, steer_go, steer_done;
  logic [IDX_W-1:0]                   rd_addr, best_idx;
  logic [2*rrt_pkg::COORD_W-1:0]      rd_data;
  rrt_pkg::best_t                     best;
  logic signed [rrt_pkg::COORD_W-1:0] new_x, new_y;
  logic                               accept;

  assign cfg_ready = 1'b1;
  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_x <= '0;
      root_y <= '0;
      step_size <= rrt_pkg::STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rrt_pkg::CFG_ROOT_X: root_x <= cfg_data;
        rrt_pkg::CFG_ROOT_Y: root_y <= cfg_data;
        rrt_pkg::CFG_STEP:   step_size <= cfg_data[rrt_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= CNT_W'(1);
      result_valid <= 1'b0;
      search_go <= 1'b0;
      steer_go <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      search_go <= 1'b0;
      steer_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sx <= {3'b000, req.sample_x, 8'h00};
            sy <= {3'b000, req.sample_y, 8'h00};
            result.new_index <= '0;
            result.parent_index <= '0;
            result.new_x <= '0;
            result.new_y <= '0;
            if (req.kind == rrt_pkg::KIND_RESTART) begin
              count <= CNT_W'(1);
              result.status <= rrt_pkg::STATUS_RESTART;
              result_valid <= 1'b1;
            end else if (count >= CNT_W'(MAX_NODES)) begin
              result.status <= rrt_pkg::STATUS_FULL;
              result_valid <= 1'b1;
            end else begin
              search_go <= 1'b1;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (search_done) begin
            steer_go <= 1'b1;
            state <= ST_STEER;
          end
        end
        ST_STEER: begin
          if (steer_done) begin
            result.new_index <= rrt_pkg::OUT_IDX_W'(count);
            result.parent_index <= rrt_pkg::OUT_IDX_W'(best_idx);
            result.new_x <= new_x;
            result.new_y <= new_y;
            result.status <= rrt_pkg::STATUS_ADDED;
            result_valid <= 1'b1;
            count <= count + CNT_W'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rrt_ram #(
    .WIDTH(2 * rrt_pkg::COORD_W),
    .DEPTH(MAX_NODES)
  ) u_ram (
    .clk  (clk),
    .we   (steer_done && (state == ST_STEER)),
    .waddr(count[IDX_W-1:0]),
    .wdata({new_x, new_y}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  rrt_search #(
    .MAX_NODES(MAX_NODES),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .go      (search_go),
    .count   (count),
    .sx      (sx),
    .sy      (sy),
    .root_x  (root_x),
    .root_y  (root_y),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (search_done),
    .best_idx(best_idx),
    .best    (best)
  );

  rrt_steer u_steer (
    .clk      (clk),
    .rst      (rst),
    .go       (steer_go),
    .best     (best),
    .sx       (sx),
    .sy       (sy),
    .step_size(step_size),
    .done     (steer_done),
    .new_x    (new_x),
    .new_y    (new_y)
  );

  `RRT_ASSERT_NEXT(a_accept_answered, accept, busy || result_valid, "request not taken up")
  `RRT_ASSERT_HOLD(a_count_bound, count <= CNT_W'(MAX_NODES) && count != '0, "bad node count")
  `RRT_ASSERT_HOLD(a_steer_in_state, !steer_done || state == ST_STEER, "steer done outside steer")

endmodule

// ===== design/rrt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the node coordinates of the tree grower.
module rrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rrt_search.sv =====
// Nearest-node scan: a chain of stage cells (read, difference, square, compare).
// Depends on rrt_pkg; reads node coordinates from the node RAM.
module rrt_search #(
  parameter int MAX_NODES = rrt_pkg::MAX_NODES_DEF,
  parameter int IDX_W = $clog2(MAX_NODES),
  parameter int CNT_W = $clog2(MAX_NODES + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [CNT_W-1:0]                 count,
  input  logic signed [rrt_pkg::DIFF_W-1:0]  sx,
  input  logic signed [rrt_pkg::DIFF_W-1:0]  sy,
  input  logic signed [rrt_pkg::COORD_W-1:0] root_x,
  input  logic signed [rrt_pkg::COORD_W-1:0] root_y,
  output logic [IDX_W-1:0]                 rd_addr,
  input  logic [2*rrt_pkg::COORD_W-1:0]    rd_data,
  output logic                             done,
  output logic [IDX_W-1:0]                 best_idx,
  output rrt_pkg::best_t                   best
);

  logic [CNT_W-1:0] issue_i;
  logic             issuing;
  logic             is_last;

  logic             v1, v2, v3;
  logic             last1, last2, last3;
  logic [IDX_W-1:0] idx1, idx2, idx3;

  logic signed [rrt_pkg::COORD_W-1:0] nx, ny;
  logic signed [rrt_pkg::COORD_W-1:0] nx2, ny2, nx3, ny3;
  logic signed [rrt_pkg::DIFF_W-1:0]  ex2, ey2;
  logic signed [2*rrt_pkg::DIFF_W-1:0] sqx3, sqy3;
  logic [rrt_pkg::D2_W-1:0]           d2;

  assign rd_addr = issue_i[IDX_W-1:0];
  assign is_last = (issue_i == count - CNT_W'(1));

  always_comb begin
    nx = (idx1 == '0) ? root_x : rd_data[2*rrt_pkg::COORD_W-1:rrt_pkg::COORD_W];
    ny = (idx1 == '0) ? root_y : rd_data[rrt_pkg::COORD_W-1:0];
    d2 = rrt_pkg::D2_W'(sqx3[31:0]) + rrt_pkg::D2_W'(sqy3[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      issue_i <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      if (go) begin
        issuing <= 1'b1;
        issue_i <= '0;
      end else if (issuing) begin
        issue_i <= issue_i + CNT_W'(1);
        if (is_last) begin
          issuing <= 1'b0;
        end
      end
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      done <= v3 && last3;
    end
    idx1 <= issue_i[IDX_W-1:0];
    last1 <= is_last;
    idx2 <= idx1;
    last2 <= last1;
    nx2 <= nx;
    ny2 <= ny;
    ex2 <= sx - rrt_pkg::DIFF_W'(nx);
    ey2 <= sy - rrt_pkg::DIFF_W'(ny);
    idx3 <= idx2;
    last3 <= last2;
    nx3 <= nx2;
    ny3 <= ny2;
    sqx3 <= ex2 * ex2;
    sqy3 <= ey2 * ey2;
    if (v3 && ((idx3 == '0) || (d2 < best.d2))) begin
      best_idx <= idx3;
      best.d2 <= d2;
      best.x <= nx3;
      best.y <= ny3;
    end
  end

endmodule

// ===== design/rrt_steer.sv =====
// Steer unit: bit-serial square root, one multiply, two serial divides, saturation.
// Depends on rrt_pkg; started by the top level once the nearest node is known.
module rrt_steer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  rrt_pkg::best_t                     best,
  input  logic signed [rrt_pkg::DIFF_W-1:0]  sx,
  input  logic signed [rrt_pkg::DIFF_W-1:0]  sy,
  input  logic [rrt_pkg::STEP_W-1:0]         step_size,
  output logic                               done,
  output logic signed [rrt_pkg::COORD_W-1:0] new_x,
  output logic signed [rrt_pkg::COORD_W-1:0] new_y
);

  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_MUL, S_DIV, S_FIN} state_t;

  state_t state;

  logic [rrt_pkg::D2_W-1:0] v, res, bitm;
  logic [rrt_pkg::D2_W:0]   trial_sq;
  logic [16:0]              norm;
  logic signed [rrt_pkg::DIFF_W-1:0] dx, dy;
  logic signed [33:0]       numx, numy;
  logic [31:0]              qx, qy;
  logic [16:0]              remx, remy;
  logic [17:0]              tx, ty;
  logic                     negx, negy;
  logic [4:0]               cnt;
  logic signed [32:0]       offx, offy;
  logic signed [rrt_pkg::D2_W-1:0] sumx, sumy;

  always_comb begin
    trial_sq = {1'b0, res} + {1'b0, bitm};
    numx = $signed({1'b0, step_size}) * dx;
    numy = $signed({1'b0, step_size}) * dy;
    tx = {remx, qx[31]};
    ty = {remy, qy[31]};
    offx = negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    offy = negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    sumx = rrt_pkg::D2_W'(best.x) + rrt_pkg::D2_W'(offx);
    sumy = rrt_pkg::D2_W'(best.y) + rrt_pkg::D2_W'(offy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            v <= best.d2;
            res <= '0;
            bitm <= rrt_pkg::D2_W'(1) << (rrt_pkg::D2_W - 2);
            dx <= sx - rrt_pkg::DIFF_W'(best.x);
            dy <= sy - rrt_pkg::DIFF_W'(best.y);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if ({1'b0, v} >= trial_sq) begin
            v <= v - trial_sq[rrt_pkg::D2_W-1:0];
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0] || bitm[1]) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          norm <= res[16:0];
          negx <= numx[33];
          negy <= numy[33];
          qx <= numx[33] ? 32'(-numx) : numx[31:0];
          qy <= numy[33] ? 32'(-numy) : numy[31:0];
          remx <= '0;
          remy <= '0;
          cnt <= '0;
          if (res == '0) begin
            new_x <= best.x;
            new_y <= best.y;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (tx >= {1'b0, norm}) begin
            remx <= 17'(tx - {1'b0, norm});
            qx <= {qx[30:0], 1'b1};
          end else begin
            remx <= tx[16:0];
            qx <= {qx[30:0], 1'b0};
          end
          if (ty >= {1'b0, norm}) begin
            remy <= 17'(ty - {1'b0, norm});
            qy <= {qy[30:0], 1'b1};
          end else begin
            remy <= ty[16:0];
            qy <= {qy[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          new_x <= rrt_pkg::sat16(sumx);
          new_y <= rrt_pkg::sat16(sumy);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
